/* sv/chol_pkg.sv */
// Package for the Cholesky decomposer: shared types and constants.
// No dependencies; compiled first.
package chol_pkg;

  localparam int ELEM_W  = 32;
  localparam int SIZE_W  = 4;
  localparam int COL_W   = 3;
  localparam int ACC_W   = 64;

  // Load-side record passed to the compute engine.
  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [COL_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              final_beat;
  } load_rec_t;

  // Result beat.
  typedef struct packed {
    logic [ELEM_W-1:0] l_value;
    logic              status;
    logic [COL_W-1:0]  fail_column;
    logic              last;
  } res_t;

  // Saturate a 66-bit signed value to 64 bits.
  function automatic logic signed [ACC_W-1:0] sat64(input logic signed [ACC_W+1:0] v);
    logic signed [ACC_W+1:0] hi;
    logic signed [ACC_W+1:0] lo;
    hi = {3'b000, {(ACC_W-1){1'b1}}};
    lo = {3'b111, {(ACC_W-1){1'b0}}};
    if (v > hi) sat64 = hi[ACC_W-1:0];
    else if (v < lo) sat64 = lo[ACC_W-1:0];
    else sat64 = v[ACC_W-1:0];
  endfunction

endpackage

/* sv/chol_if.sv */
// Valid/ready stream interfaces for the Cholesky decomposer.
// No dependencies.
interface chol_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] elem_value;
  modport source (output valid, output elem_value, input ready);
  modport sink   (input valid, input elem_value, output ready);
endinterface

interface chol_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] l_value;
  logic        status;
  logic [2:0]  fail_column;
  logic        last;
  modport source (output valid, output l_value, output status, output fail_column,
                  output last, input ready);
  modport sink   (input valid, input l_value, input status, input fail_column,
                  input last, output ready);
endinterface

/* sv/chol_front.sv */
// Front end: accepts element beats, tracks row/column and run end.
// Depends on chol_pkg.
module chol_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [3:0]               cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              in_data,
  output logic                     q_push,
  input  logic                     q_full,
  output chol_pkg::load_rec_t      q_rec,
  output logic [2:0]               order_m1
);
  import chol_pkg::*;

  logic [3:0] matrix_size;
  logic [2:0] row;
  logic [2:0] col;
  logic [3:0] eff;

  // Clamp the configured order into 1..8.
  always_comb begin
    if (matrix_size == 4'd0) eff = 4'd1;
    else if (matrix_size > 4'd8) eff = 4'd8;
    else eff = matrix_size;
  end
  assign order_m1 = 3'(eff - 4'd1);

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_rec.value = in_data;
  assign q_rec.row   = row;
  assign q_rec.col   = col;
  assign q_rec.final_beat = (row == order_m1) && (col == order_m1);

  // Advance position; a config write restarts loading.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= 4'd8;
      row <= '0;
      col <= '0;
    end else if (cfg_we) begin
      matrix_size <= cfg_wdata;
      row <= '0;
      col <= '0;
    end else if (q_push) begin
      if (col == order_m1) begin
        col <= '0;
        row <= (row == order_m1) ? 3'd0 : row + 3'd1;
      end else begin
        col <= col + 3'd1;
      end
    end
  end
endmodule

/* sv/chol_queue.sv */
// Short FIFO between front end and compute engine.
// Depends on chol_pkg.
module chol_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  chol_pkg::load_rec_t wdata,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output chol_pkg::load_rec_t rdata
);
  import chol_pkg::*;
  localparam int AW = $clog2(DEPTH);

  load_rec_t       slots [DEPTH];
  logic [AW-1:0]   wptr;
  logic [AW-1:0]   rptr;
  logic [AW:0]     count;

  assign full  = (count == (AW+1)'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rptr];

  // Store beats.
  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wdata;
  end

  // Move pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

/* sv/chol_engine.sv */
// Back end: stores A, factors it with a serial MAC, sqrt and divider, emits L.
// Depends on chol_pkg.
module chol_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          order_m1,
  input  logic                q_empty,
  input  chol_pkg::load_rec_t q_rec,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output chol_pkg::res_t      out_res
);
  import chol_pkg::*;

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_MAC   = 10'b0000000010,
    S_MACW  = 10'b0000000100,
    S_MACA  = 10'b0000001000,
    S_SQRT  = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_STORE = 10'b0001000000,
    S_ERR   = 10'b0010000000,
    S_EMITR = 10'b0100000000,
    S_EMIT  = 10'b1000000000
  } state_t;

  state_t state;
  logic signed [31:0] a_mem [64];
  logic signed [31:0] l_mem [64];

  logic [2:0] i, j, k;
  logic [2:0] ei, ej;
  logic signed [31:0] a_rd, la_rd, lb_rd, pivot;
  logic signed [63:0] prod, acc;
  logic [63:0] rem, root, bitm;
  logic [6:0]  dcnt;
  logic        neg;
  logic [63:0] dvd_mag, quo;
  logic [64:0] drem;
  logic [31:0] dvs;
  logic signed [31:0] result;
  logic signed [31:0] root_sat;
  logic [5:0]  ra, rb;
  logic        emit_hold;

  logic signed [65:0] num_wide;
  logic signed [63:0] num;
  logic [64:0] trial;
  logic [64:0] dsh;
  logic signed [64:0] qs;

  // Write A as beats arrive.
  assign q_pop = (state == S_LOAD) && !q_empty;
  always_ff @(posedge clk) begin
    if (q_pop) a_mem[{q_rec.row, q_rec.col}] <= q_rec.value;
  end

  // Registered reads for the MAC and output.
  always_comb begin
    ra = {i, k};
    rb = {j, k};
    if (state == S_EMITR || state == S_EMIT) ra = {ei, ej};
  end
  always_ff @(posedge clk) begin
    la_rd <= l_mem[ra];
    lb_rd <= l_mem[rb];
    a_rd  <= a_mem[{i, j}];
  end

  // Numerator (diagonal or off-diagonal) from A scaled minus accumulated sum.
  assign num_wide = (66'(a_rd) <<< 16) - 66'(acc);
  assign num      = sat64(num_wide);
  assign trial    = {1'b0, rem} - ({1'b0, root} + {1'b0, bitm});
  assign dsh      = {drem[63:0], dvd_mag[63]};
  assign qs       = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // Clamp the finished root to the element range.
  assign root_sat = (root > 64'h7fffffff) ? 32'sh7fffffff : root[31:0];

  // Result saturation for the divider.
  always_comb begin
    if (qs > 65'sd2147483647) result = 32'sh7fffffff;
    else if (qs < -65'sd2147483648) result = 32'sh80000000;
    else result = qs[31:0];
  end

  assign out_valid = (state == S_EMIT) || (state == S_ERR);

  always_ff @(posedge clk) begin
    if (state == S_STORE) l_mem[{i, j}] <= (i == j) ? root_sat : result;
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      state <= S_LOAD;
      i <= '0; j <= '0; k <= '0; ei <= '0; ej <= '0;
      emit_hold <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (q_pop && q_rec.final_beat) begin
            j <= '0; i <= '0; k <= '0; acc <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          state <= S_MACW;
        end
        S_MACW: begin
          prod <= 64'(la_rd) * 64'(lb_rd);
          state <= S_MACA;
        end
        S_MACA: begin
          if (k < j) begin
            acc <= sat64(66'(acc) + 66'(prod));
            k <= k + 3'd1;
            state <= S_MAC;
          end else if (i == j) begin
            if (num <= 0) begin
              state <= S_ERR;
            end else begin
              rem <= num; root <= '0; bitm <= 64'h4000000000000000;
              state <= S_SQRT;
            end
          end else begin
            neg <= num[63] ^ pivot[31];
            dvd_mag <= num[63] ? 64'(-num) : 64'(num);
            dvs <= pivot[31] ? 32'(-pivot) : 32'(pivot);
            drem <= '0; quo <= '0; dcnt <= '0;
            state <= S_DIV;
          end
        end
        S_SQRT: begin
          if (!trial[64]) begin
            rem <= trial[63:0];
            root <= (root >> 1) + bitm;
          end else begin
            root <= root >> 1;
          end
          bitm <= bitm >> 2;
          if (bitm == 64'd1) state <= S_STORE;
        end
        S_DIV: begin
          dvd_mag <= dvd_mag << 1;
          if (dsh >= {33'd0, dvs}) begin
            drem <= dsh - {33'd0, dvs};
            quo <= {quo[62:0], 1'b1};
          end else begin
            drem <= dsh;
            quo <= {quo[62:0], 1'b0};
          end
          dcnt <= dcnt + 7'd1;
          if (dcnt == 7'd63) state <= S_STORE;
        end
        S_STORE: begin
          if (i == j) begin
            pivot <= root_sat;
          end
          acc <= '0; k <= '0;
          if (i == order_m1) begin
            if (j == order_m1) begin
              ei <= '0; ej <= '0;
              state <= S_EMITR;
            end else begin
              j <= j + 3'd1; i <= j + 3'd1;
              state <= S_MAC;
            end
          end else begin
            i <= i + 3'd1;
            state <= S_MAC;
          end
        end
        S_ERR: begin
          if (out_ready) state <= S_LOAD;
        end
        S_EMITR: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_ready) begin
            if (ei == order_m1 && ej == order_m1) begin
              state <= S_LOAD;
            end else begin
              if (ej == order_m1) begin
                ej <= '0; ei <= ei + 3'd1;
              end else begin
                ej <= ej + 3'd1;
              end
              state <= S_EMITR;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
      emit_hold <= 1'b0;
    end
  end

  // Pivot register feeds the divider; the finished root is written to L and to the pivot.
  always_comb begin
    out_res.status      = (state == S_ERR);
    out_res.fail_column = (state == S_ERR) ? j : 3'd0;
    out_res.last        = (state == S_ERR) ||
                          (ei == order_m1 && ej == order_m1);
    if (state == S_ERR) out_res.l_value = '0;
    else if (ej > ei || emit_hold) out_res.l_value = '0;
    else out_res.l_value = la_rd;
  end
endmodule

/* sv/cholesky_decomposer_top.sv */
// Cholesky decomposer: loads an n-by-n Q16.16 matrix at one element per
// cycle while the input queue has room, factors it with one shared serial
// multiply-accumulate, a 32-step square root and a 64-step divider, then
// emits L row-major, holding each beat until the sink is ready, or a single
// error beat when a diagonal term is not positive.
// Depends on chol_pkg and chol_if.
module cholesky_decomposer_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  chol_in_if.sink    in_ch,
  chol_out_if.source out_ch
);
  import chol_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  load_rec_t q_wrec, q_rrec;
  logic [2:0] order_m1;
  res_t      res;

  chol_front u_front (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.elem_value),
    .q_push, .q_full, .q_rec(q_wrec), .order_m1
  );

  chol_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst(rst || cfg_we), .push(q_push), .wdata(q_wrec), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_rrec)
  );

  chol_engine u_engine (
    .clk, .rst, .cfg_we, .order_m1, .q_empty, .q_rec(q_rrec), .q_pop,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );

  assign out_ch.l_value     = res.l_value;
  assign out_ch.status      = res.status;
  assign out_ch.fail_column = res.fail_column;
  assign out_ch.last        = res.last;
endmodule

/* sv/chol_checker.sv */
// Port-level checker for the Cholesky decomposer, bound to the top level.
// Depends on the top level's ports only.
module chol_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       status,
  input logic       last,
  input logic [2:0] fail_column,
  input logic [31:0] l_value
);
  // An error beat is always the last beat.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> last) else $error("error beat without last");
  // An error beat carries zero data.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> l_value == 32'd0) else $error("error beat data nonzero");
  // Success beats report column zero.
  a_ok_col: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status |-> fail_column == 3'd0) else $error("fail column on success");
  // A stalled beat holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(l_value)) else $error("beat dropped");
endmodule

bind cholesky_decomposer_top chol_checker u_chk (
  .clk, .rst, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .status(out_ch.status), .last(out_ch.last), .fail_column(out_ch.fail_column),
  .l_value(out_ch.l_value)
);
